// File: src/rccfb_pkg.sv
// ----------------------------------------------------------------------------
// rccfb_pkg
// Shared types, frame constants and the table driven CRC16 step for the
// RC channel frame builder.
// ----------------------------------------------------------------------------
package rccfb_pkg;

  // Number of hop channels the index wraps at
  localparam int unsigned HOP_COUNT = 47;

  // Frame lengths and length bytes
  localparam logic [5:0] FRAME_LEN_SHORT = 6'd30;
  localparam logic [5:0] FRAME_LEN_LONG  = 6'd33;
  localparam logic [7:0] LEN_BYTE_SHORT  = 8'h1D;
  localparam logic [7:0] LEN_BYTE_LONG   = 8'h20;

  // Fixed header / trailer bytes
  localparam logic [7:0] PKT_TYPE_BYTE = 8'h02;
  localparam logic [7:0] PKT_FLAG_BYTE = 8'h01;
  localparam logic [7:0] PKT_TAIL_BYTE = 8'h08;

  // First byte covered by the CRC
  localparam logic [5:0] CRC_START_IDX = 6'd3;

  // Mapped value of 1500 us with the upper-half flag (bit 11) set
  localparam logic [11:0] UPPER_CHAN_VAL = 12'hC00;

  // Channel mapping constants
  localparam logic [15:0] CHAN_OFFSET = 16'd860;
  localparam logic [15:0] CHAN_BIAS   = 16'd64;

  typedef logic [11:0] chan_t;
  typedef chan_t [7:0] chan_set_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_TX_ID     = 2'd0,
    CFG_LONG_MODE = 2'd1,
    CFG_HOP_STEP  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] tx_id;
    logic        long_mode;
    logic [5:0]  hop_step;
  } cfg_t;

  // Mapped channel set handed from the input stage to the serializer
  typedef struct packed {
    logic      valid;
    chan_set_t chans;
  } hold_t;

  // CRC term tables: low nibble table and 0x1081 times the high nibble
  localparam logic [15:0] CRC_LO_TBL [16] = '{
    16'h0000, 16'h1189, 16'h2312, 16'h329B, 16'h4624, 16'h57AD, 16'h6536, 16'h74BF,
    16'h8C48, 16'h9DC1, 16'hAF5A, 16'hBED3, 16'hCA6C, 16'hDBE5, 16'hE97E, 16'hF8F7
  };
  localparam logic [15:0] CRC_HI_TBL [16] = '{
    16'h0000, 16'h1081, 16'h2102, 16'h3183, 16'h4204, 16'h5285, 16'h6306, 16'h7387,
    16'h8408, 16'h9489, 16'hA50A, 16'hB58B, 16'hC60C, 16'hD68D, 16'hE70E, 16'hF78F
  };

  // One byte of CRC16
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc[15:8] ^ b;
    return {crc[7:0], 8'h00} ^ CRC_LO_TBL[v[3:0]] ^ CRC_HI_TBL[v[7:4]];
  endfunction

endpackage

// File: src/rccfb_in_stage.sv
// ----------------------------------------------------------------------------
// rccfb_in_stage
// Input holding register: maps the eight channels on acceptance and keeps
// them until the serializer takes them for the next frame.
// ----------------------------------------------------------------------------
module rccfb_in_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rccfb_pkg::chan_set_t in_chans,
  input  logic                 take,
  output rccfb_pkg::hold_t     hold
);
  import rccfb_pkg::*;

  logic      hold_valid_r;
  logic      hold_valid_nxt;
  chan_set_t chans_r;
  chan_set_t mapped;
  logic      accept;

  // m = floor((v - 860) * 3 / 2) + 64, low 12 bits
  function automatic chan_t map_channel(input chan_t v);
    logic [15:0] d;
    logic [15:0] x;
    logic [15:0] h;
    d = {4'd0, v} - CHAN_OFFSET;
    x = d + {d[14:0], 1'b0};
    h = {x[15], x[15:1]} + CHAN_BIAS;
    return h[11:0];
  endfunction

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      mapped[i] = map_channel(in_chans[i]);
    end
  end

  // Free slot, or the slot empties this cycle
  assign in_ready = !hold_valid_r || take;
  assign accept   = in_valid && in_ready;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (accept) begin
      hold_valid_nxt = 1'b1;
    end else if (take) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      chans_r <= mapped;
    end
  end

  assign hold.valid = hold_valid_r;
  assign hold.chans = chans_r;

endmodule

// File: src/rccfb_serializer.sv
// ----------------------------------------------------------------------------
// rccfb_serializer
// Frame sequencer: holds one frame's channels, steps the hop state, emits
// the frame a byte a cycle, unless the output stalls, through an output register and runs the CRC.
// ----------------------------------------------------------------------------
module rccfb_serializer (
  input  logic             clk,
  input  logic             rst_n,
  input  rccfb_pkg::cfg_t  cfg,
  input  rccfb_pkg::hold_t hold,
  output logic             take,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_frame_byte,
  output logic             out_last_byte
);
  import rccfb_pkg::*;

  localparam logic [6:0] HOP_MOD = 7'(HOP_COUNT);

  logic        active_r,   active_nxt;
  logic [5:0]  idx_r,      idx_nxt;
  logic [15:0] crc_r,      crc_nxt;
  logic [5:0]  hop_r,      hop_nxt;
  logic        upper_r,    upper_nxt;
  logic        cur_upper_r;
  chan_set_t   chans_r;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r;
  logic        out_last_r;

  logic [5:0]  frame_len;
  logic        adv;
  logic        is_last;
  logic        load;
  logic [7:0]  body_byte;
  logic [7:0]  cur_byte;
  logic        crc_en;
  chan_set_t   ch;
  logic [6:0]  hop_sum;
  logic [6:0]  hop_red1;
  logic [6:0]  hop_red2;

  assign frame_len = cfg.long_mode ? FRAME_LEN_LONG : FRAME_LEN_SHORT;

  // Emit the next byte when the output register is free or being drained
  assign adv     = active_r && (!out_valid_r || out_ready);
  assign is_last = (idx_r == frame_len - 6'd1);
  assign load    = hold.valid && (!active_r || (adv && is_last));
  assign take    = load;

  // Hop index advance: sum stays below three wraps
  assign hop_sum  = {1'b0, hop_r} + {1'b0, cfg.hop_step};
  assign hop_red1 = (hop_sum >= HOP_MOD) ? hop_sum - HOP_MOD : hop_sum;
  assign hop_red2 = (hop_red1 >= HOP_MOD) ? hop_red1 - HOP_MOD : hop_red1;

  // Channel source for this frame
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      ch[i] = cur_upper_r ? UPPER_CHAN_VAL : chans_r[i];
    end
  end

  // Frame body byte at the current index
  always_comb begin
    case (idx_r)
      6'd0:    body_byte = cfg.long_mode ? LEN_BYTE_LONG : LEN_BYTE_SHORT;
      6'd1:    body_byte = cfg.tx_id[15:8];
      6'd2:    body_byte = cfg.tx_id[7:0];
      6'd3:    body_byte = PKT_TYPE_BYTE;
      6'd4:    body_byte = {cfg.hop_step[1:0], 6'd0} + {2'd0, hop_r};
      6'd5:    body_byte = {4'd0, cfg.hop_step[5:2]};
      6'd6:    body_byte = PKT_FLAG_BYTE;
      6'd9:    body_byte = ch[0][7:0];
      6'd10:   body_byte = {ch[1][3:0], ch[0][11:8]};
      6'd11:   body_byte = ch[1][11:4];
      6'd12:   body_byte = ch[2][7:0];
      6'd13:   body_byte = {ch[3][3:0], ch[2][11:8]};
      6'd14:   body_byte = ch[3][11:4];
      6'd15:   body_byte = ch[4][7:0];
      6'd16:   body_byte = {ch[5][3:0], ch[4][11:8]};
      6'd17:   body_byte = ch[5][11:4];
      6'd18:   body_byte = ch[6][7:0];
      6'd19:   body_byte = {ch[7][3:0], ch[6][11:8]};
      6'd20:   body_byte = ch[7][11:4];
      6'd21:   body_byte = PKT_TAIL_BYTE;
      default: body_byte = 8'h00;
    endcase
  end

  // CRC trailer overrides the body at the last two positions
  always_comb begin
    cur_byte = body_byte;
    if (idx_r == frame_len - 6'd2) begin
      cur_byte = crc_r[15:8];
    end else if (is_last) begin
      cur_byte = crc_r[7:0];
    end
  end

  assign crc_en = (idx_r >= CRC_START_IDX) && (idx_r < frame_len - 6'd2);

  // Sequencer next state
  always_comb begin
    active_nxt    = active_r;
    idx_nxt       = idx_r;
    crc_nxt       = crc_r;
    hop_nxt       = hop_r;
    upper_nxt     = upper_r;
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = idx_r + 6'd1;
      if (crc_en) begin
        crc_nxt = crc_step(crc_r, body_byte);
      end
      if (is_last) begin
        active_nxt = 1'b0;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      active_nxt = 1'b1;
      idx_nxt    = 6'd0;
      crc_nxt    = 16'h0000;
      hop_nxt    = hop_red2[5:0];
      upper_nxt  = !upper_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      idx_r       <= 6'd0;
      crc_r       <= 16'h0000;
      hop_r       <= 6'd0;
      upper_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      idx_r       <= idx_nxt;
      crc_r       <= crc_nxt;
      hop_r       <= hop_nxt;
      upper_r     <= upper_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Frame payload and output data registers
  always_ff @(posedge clk) begin
    if (load) begin
      chans_r     <= hold.chans;
      cur_upper_r <= upper_r;
    end
    if (adv) begin
      out_byte_r <= cur_byte;
      out_last_r <= is_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_frame_byte = out_byte_r;
  assign out_last_byte  = out_last_r;

  // Checks
  a_idx_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (idx_r < frame_len))
    else $error("byte index ran past the frame end");

  a_load_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (active_r && (idx_r == 6'd0) && (crc_r == 16'h0000)))
    else $error("frame load did not restart the sequencer");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && is_last) |=> (out_valid_r && out_last_r))
    else $error("final byte not flagged as last");

  a_hop_range: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (hop_r < 6'(HOP_COUNT)))
    else $error("hop index out of range");

endmodule

// File: src/rc_channel_frame_builder.sv
// ----------------------------------------------------------------------------
// rc_channel_frame_builder
// Builds one CRC16 closed radio frame per accepted channel transaction.
// ----------------------------------------------------------------------------
// Data path: the input holding register, the sequencer state, then the single
// byte-wide output register. Throughput: one byte per cycle unless out_ready
//   stalls, 30 (short) or 33 (long) bytes per frame; frames run back to back.
// A second transaction is held in the input register while a frame streams.
// Reset (rst_n low, synchronous): hop index 0, even frame first, id 0,
//   short mode, hop step 1, input holding register empty.
// ----------------------------------------------------------------------------
module rc_channel_frame_builder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [11:0] in_ch0,
  input  logic [11:0] in_ch1,
  input  logic [11:0] in_ch2,
  input  logic [11:0] in_ch3,
  input  logic [11:0] in_ch4,
  input  logic [11:0] in_ch5,
  input  logic [11:0] in_ch6,
  input  logic [11:0] in_ch7,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_frame_byte,
  output logic        out_last_byte
);
  import rccfb_pkg::*;

  cfg_t      cfg_r;
  chan_set_t in_chans;
  hold_t     hold;
  logic      take;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tx_id     <= 16'd0;
      cfg_r.long_mode <= 1'b0;
      cfg_r.hop_step  <= 6'd1;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TX_ID:     cfg_r.tx_id     <= cfg_wdata;
        CFG_LONG_MODE: cfg_r.long_mode <= cfg_wdata[0];
        CFG_HOP_STEP:  cfg_r.hop_step  <= cfg_wdata[5:0];
        default:       ;
      endcase
    end
  end

  assign in_chans = {in_ch7, in_ch6, in_ch5, in_ch4, in_ch3, in_ch2, in_ch1, in_ch0};

  rccfb_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_chans (in_chans),
    .take     (take),
    .hold     (hold)
  );

  rccfb_serializer u_serializer (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .hold           (hold),
    .take           (take),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_frame_byte (out_frame_byte),
    .out_last_byte  (out_last_byte)
  );

endmodule

// File: tb/rc_channel_frame_builder_test.sv
// ----------------------------------------------------------------------------
// rc_channel_frame_builder_test
// Self-checking bench for the RC channel frame builder. Channel transactions
// go in, and each byte of the frame that comes out is compared with a frame
// built by the bench's own copy of the hop counter, the channel mapping, the
// packing and the CRC16. Directed frames cover the register and channel
// extremes. Random traffic then runs under several idle and stall mixes, and
// one phase applies a long output stall to fill the block.
// ----------------------------------------------------------------------------
module rc_channel_frame_builder_test;
  import rccfb_pkg::*;

  localparam int HOPS          = 47;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 300;
  localparam int IDLE_LIMIT    = 3000;

  // Frame constants, kept local so the prediction stands on its own
  localparam logic [7:0] LEN_SHORT_BYTE = 8'h1D;
  localparam logic [7:0] LEN_LONG_BYTE  = 8'h20;
  localparam logic [7:0] TYPE_BYTE      = 8'h02;
  localparam logic [7:0] FLAG_BYTE      = 8'h01;
  localparam logic [7:0] TAIL_BYTE      = 8'h08;
  localparam logic [15:0] CRC_HI_MUL    = 16'h1081;
  localparam logic [15:0] CRC_NIBBLE [16] = '{
    16'h0000, 16'h1189, 16'h2312, 16'h329B, 16'h4624, 16'h57AD, 16'h6536, 16'h74BF,
    16'h8C48, 16'h9DC1, 16'hAF5A, 16'hBED3, 16'hCA6C, 16'hDBE5, 16'hE97E, 16'hF8F7
  };

  typedef struct {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_TX_ID;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [11:0] in_ch0 = '0, in_ch1 = '0, in_ch2 = '0, in_ch3 = '0;
  logic [11:0] in_ch4 = '0, in_ch5 = '0, in_ch6 = '0, in_ch7 = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_frame_byte;
  logic        out_last_byte;

  // Shadow of the registers and the frame state
  logic [15:0] link_id;
  logic        long_frames;
  logic [5:0]  hop_step;
  logic [5:0]  hop_pos;
  logic        odd_frame;

  frame_byte_t frame_bytes_due[$];
  int          fail_count = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  bit          hold_req = 1'b0;
  int          idle_cycles = 0;

  rc_channel_frame_builder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_ch0         (in_ch0),
    .in_ch1         (in_ch1),
    .in_ch2         (in_ch2),
    .in_ch3         (in_ch3),
    .in_ch4         (in_ch4),
    .in_ch5         (in_ch5),
    .in_ch6         (in_ch6),
    .in_ch7         (in_ch7),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_frame_byte (out_frame_byte),
    .out_last_byte  (out_last_byte)
  );

  always #1 clk = ~clk;

  // Pulse width to 12-bit link value; the halving rounds toward minus infinity
  function automatic logic [11:0] map_pulse(input logic [11:0] pulse);
    int scaled;
    scaled = (int'(pulse) - 860) * 3;
    return 12'((scaled >>> 1) + 64);
  endfunction

  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc[15:8] ^ b;
    return {crc[7:0], 8'h00} ^ CRC_NIBBLE[v[3:0]] ^ 16'(CRC_HI_MUL * v[7:4]);
  endfunction

  // Advance the hop state and queue every byte of the frame this transaction makes
  function automatic void predict_frame(input chan_set_t chans);
    logic [7:0]  fr [33];
    logic [11:0] link_val [8];
    logic [15:0] crc;
    int          len;
    hop_pos = 6'((int'(hop_pos) + int'(hop_step)) % HOPS);
    len = long_frames ? 33 : 30;
    foreach (fr[i]) fr[i] = 8'h00;
    fr[0] = long_frames ? LEN_LONG_BYTE : LEN_SHORT_BYTE;
    fr[1] = link_id[15:8];
    fr[2] = link_id[7:0];
    fr[3] = TYPE_BYTE;
    fr[4] = {hop_step[1:0], hop_pos};
    fr[5] = {4'h0, hop_step[5:2]};
    fr[6] = FLAG_BYTE;
    for (int i = 0; i < 8; i++)
      link_val[i] = odd_frame ? (map_pulse(12'd1500) | 12'h800) : map_pulse(chans[i]);
    for (int i = 0; i < 4; i++) begin
      fr[9 + 3*i]  = link_val[2*i][7:0];
      fr[10 + 3*i] = {link_val[2*i+1][3:0], link_val[2*i][11:8]};
      fr[11 + 3*i] = link_val[2*i+1][11:4];
    end
    fr[21] = TAIL_BYTE;
    odd_frame = ~odd_frame;
    crc = 16'h0000;
    for (int i = 3; i < len - 2; i++) crc = crc16_update(crc, fr[i]);
    fr[len-2] = crc[15:8];
    fr[len-1] = crc[7:0];
    for (int i = 0; i < len; i++) frame_bytes_due.push_back('{fr[i], i == len - 1});
  endfunction

  // Random channel set: mostly stick range, some anywhere, some at the edges
  function automatic chan_set_t rand_chans();
    chan_set_t c;
    int pick;
    for (int i = 0; i < 8; i++) begin
      pick = $urandom_range(9);
      if (pick < 6) c[i] = 12'($urandom_range(860, 2140));
      else if (pick < 8) c[i] = 12'($urandom);
      else begin
        case ($urandom_range(4))
          0: c[i] = 12'd0;
          1: c[i] = 12'd859;
          2: c[i] = 12'd860;
          3: c[i] = 12'd861;
          default: c[i] = 12'hFFF;
        endcase
      end
    end
    return c;
  endfunction

  function automatic chan_set_t same_chans(input logic [11:0] v);
    chan_set_t c;
    for (int i = 0; i < 8; i++) c[i] = v;
    return c;
  endfunction

  // Config write: one cycle with the enable high
  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_TX_ID:     link_id = value;
      CFG_LONG_MODE: long_frames = value[0];
      CFG_HOP_STEP:  hop_step = value[5:0];
      default: ;
    endcase
  endtask

  // All three registers; junk fills the bits above narrow registers
  task automatic set_config(input logic [15:0] id, input logic long_mode,
                            input logic [5:0] step, input bit junk);
    logic [15:0] fill;
    fill = junk ? 16'($urandom) : 16'h0000;
    write_reg(CFG_TX_ID, id);
    write_reg(CFG_LONG_MODE, {fill[15:1], long_mode});
    write_reg(CFG_HOP_STEP, {fill[15:6], step});
  endtask

  // One transaction on the channel input, with a random gap ahead of it
  task automatic offer_channels(input chan_set_t chans);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_ch0 <= chans[0];
    in_ch1 <= chans[1];
    in_ch2 <= chans[2];
    in_ch3 <= chans[3];
    in_ch4 <= chans[4];
    in_ch5 <= chans[5];
    in_ch6 <= chans[6];
    in_ch7 <= chans[7];
    predict_frame(chans);
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid, let every queued byte come out, then give the pipe time to empty
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (frame_bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Reset values of the registers; channel extremes on even frames
  task automatic test_default_frames();
    send_idle_pct = 0;
    stall_pct = 0;
    offer_channels(same_chans(12'd0));
    offer_channels(same_chans(12'hFFF));
    offer_channels(same_chans(12'hFFF));
    offer_channels(same_chans(12'hAAA));
    offer_channels('{12'd3000, 12'd2140, 12'd2139, 12'd1500,
                     12'd862, 12'd861, 12'd860, 12'd859});
    offer_channels(same_chans(12'h555));
    settle_idle();
  endtask

  // Widest id, long frames, largest in-range step; then a zero step and steps outside the hop range
  task automatic test_register_extremes();
    set_config(16'hFFFF, 1'b1, 6'd46, 1'b0);
    repeat (4) offer_channels(rand_chans());
    settle_idle();
    set_config(16'h0000, 1'b0, 6'd0, 1'b1);
    repeat (3) offer_channels(rand_chans());
    settle_idle();
    set_config(16'h8001, 1'b1, 6'd63, 1'b1);
    repeat (4) offer_channels(rand_chans());
    settle_idle();
    set_config(16'h7FFE, 1'b0, 6'd47, 1'b0);
    repeat (2) offer_channels(rand_chans());
    settle_idle();
  endtask

  // Random traffic under one idle mix; registers change once midway
  task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                     input int count);
    logic [5:0] step;
    send_idle_pct = sender_pct;
    stall_pct = receiver_pct;
    for (int half = 0; half < 2; half++) begin
      step = ($urandom_range(7) == 0) ? 6'($urandom) : 6'($urandom_range(1, 46));
      set_config(16'($urandom), 1'($urandom), step, 1'($urandom_range(1)));
      for (int n = 0; n < count / 2; n++) offer_channels(rand_chans());
      settle_idle();
    end
  endtask

  // Long output stall while inputs keep coming, so the block stalls its input
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_req = 1'b1;
    repeat (8) offer_channels(rand_chans());
    settle_idle();
  endtask

  // Output side: random stalls, and one long hold-off when asked
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      out_ready <= rst_n && ($urandom_range(99) >= stall_pct);
    end
  end

  // Compare each byte transaction with the oldest predicted byte
  always @(posedge clk) begin
    frame_byte_t want;
    if (rst_n && out_valid && out_ready) begin
      if (frame_bytes_due.size() == 0) begin
        $error("unexpected transaction: frame_byte %02h last_byte %0b",
               out_frame_byte, out_last_byte);
        fail_count++;
      end else begin
        want = frame_bytes_due.pop_front();
        if (out_frame_byte !== want.data) begin
          $error("frame_byte: expected %02h, actual %02h", want.data, out_frame_byte);
          fail_count++;
        end
        if (out_last_byte !== want.last) begin
          $error("last_byte: expected %0b, actual %0b", want.last, out_last_byte);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    link_id = 16'h0000;
    long_frames = 1'b0;
    hop_step = 6'd1;
    hop_pos = 6'd0;
    odd_frame = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_frames();
    test_register_extremes();
    test_random_traffic(0, 0, 96);
    test_random_traffic(49, 0, 96);
    test_random_traffic(0, 49, 96);
    test_random_traffic(9, 9, 96);
    test_backpressure();

    settle_idle();
    if (frame_bytes_due.size() != 0) begin
      $error("%0d predicted frame bytes never arrived", frame_bytes_due.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/rccfb_pkg.sv
src/rccfb_in_stage.sv
src/rccfb_serializer.sv
src/rc_channel_frame_builder.sv
tb/rc_channel_frame_builder_test.sv
